// ----- design/contiguous_page_allocator_assert.svh -----
// Assertion macros for the contiguous page allocator.
// Used by the top level only; no other dependencies.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked and reset-qualified.
`define CPA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("contiguous_page_allocator: same-cycle check failed");

// Next-cycle implication, clocked and reset-qualified.
`define CPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("contiguous_page_allocator: next-cycle check failed");

`endif

// ----- design/cpa_pkg.sv -----
// Shared types and constants for the contiguous page allocator.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package cpa_pkg;

    localparam int MAX_PAGES_DEF  = 1024;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int WORD_BITS      = 32;   // bitmap word width
    localparam int COUNT_W        = 11;   // page_count / pool_pages width
    localparam int VPU_W          = 21;   // virtual heap page counter width

    localparam logic [31:0]        PHYS_BASE_RST  = 32'h0010_2000;
    localparam logic [COUNT_W-1:0] POOL_PAGES_RST = 11'd1024;
    localparam logic [31:0]        HEAP_START_RST = 32'hC010_0000;
    localparam logic [31:0]        HEAP_LIMIT_RST = 32'hFFC0_0000;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_BAD_POOL = 3'd1,
        STAT_NO_VIRT  = 3'd2,
        STAT_NO_RUN   = 3'd3,
        STAT_ZERO     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_PHYS_BASE  = 2'd0,
        CFG_POOL_PAGES = 2'd1,
        CFG_HEAP_START = 2'd2,
        CFG_HEAP_LIMIT = 2'd3
    } cfg_idx_t;

    // Controller -> datapath
    typedef struct packed {
        logic    clear_wr;
        logic    load;
        logic    set_status;
        status_t code;
        logic    srch_init;
        logic    srch_next;
        logic    mark_init;
        logic    mark_wr;
        logic    emit;
    } cpa_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic req_kernel;
        logic req_zero;
        logic no_virt;
        logic lim_zero;
        logic hit;
        logic srch_last;
        logic mark_last;
        logic out_free;
    } cpa_sts_t;

endpackage

`default_nettype wire

// ----- design/cpa_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/cpa_ctrl.sv -----
// Sequencing state machine for the contiguous page allocator.
// Depends on cpa_pkg for the command/status structs and status codes.
`default_nettype none

module cpa_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire cpa_pkg::cpa_sts_t sts,
    output cpa_pkg::cpa_cmd_t      cmd
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_CHECK1  = 10'b00_0000_0100,
        S_CHECK2  = 10'b00_0000_1000,
        S_SRCH_RD = 10'b00_0001_0000,
        S_SRCH_EV = 10'b00_0010_0000,
        S_MARK_IN = 10'b00_0100_0000,
        S_MARK_RD = 10'b00_1000_0000,
        S_MARK_WR = 10'b01_0000_0000,
        S_RESULT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK1;
                end
            end
            // products for the heap check land in registers here
            S_CHECK1: state_next = S_CHECK2;
            S_CHECK2: begin
                state_next     = S_RESULT;
                cmd.set_status = 1'b1;
                priority if (!sts.req_kernel) begin
                    cmd.code = cpa_pkg::STAT_BAD_POOL;
                end else if (sts.req_zero) begin
                    cmd.code = cpa_pkg::STAT_ZERO;
                end else if (sts.no_virt) begin
                    cmd.code = cpa_pkg::STAT_NO_VIRT;
                end else if (sts.lim_zero) begin
                    cmd.code = cpa_pkg::STAT_NO_RUN;
                end else begin
                    cmd.set_status = 1'b0;
                    cmd.srch_init  = 1'b1;
                    state_next     = S_SRCH_RD;
                end
            end
            S_SRCH_RD: state_next = S_SRCH_EV;
            S_SRCH_EV: begin
                priority if (sts.hit) begin
                    state_next = S_MARK_IN;
                end else if (sts.srch_last) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = cpa_pkg::STAT_NO_RUN;
                    state_next     = S_RESULT;
                end else begin
                    cmd.srch_next = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_MARK_IN: begin
                cmd.mark_init  = 1'b1;
                cmd.set_status = 1'b1;
                cmd.code       = cpa_pkg::STAT_OK;
                state_next     = S_MARK_RD;
            end
            S_MARK_RD: state_next = S_MARK_WR;
            S_MARK_WR: begin
                cmd.mark_wr = 1'b1;
                state_next  = sts.mark_last ? S_RESULT : S_MARK_RD;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/cpa_dp.sv -----
// Datapath: config registers, heap check, word-serial bitmap search and marking.
// Depends on cpa_pkg and cpa_ram.
`default_nettype none

module cpa_dp #(
    parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cpa_pkg::cpa_cmd_t cmd,
    output cpa_pkg::cpa_sts_t      sts,
    input  wire logic [0:0]        s_tuser,
    input  wire logic [15:0]       s_tdata,
    input  wire logic              cfg_valid,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [2:0]             m_tuser,
    output logic [63:0]            m_tdata
);

    localparam int W      = cpa_pkg::WORD_BITS;
    localparam int WB     = $clog2(W);
    localparam int CNT_W  = cpa_pkg::COUNT_W;
    localparam int VPU_W  = cpa_pkg::VPU_W;
    localparam int NW     = (MAX_PAGES + W - 1) / W;
    localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
    localparam int PIDX_W = AW + WB;
    localparam int PG_W   = $clog2(MAX_PAGES + 1);
    localparam int PGX_W  = (PG_W > CNT_W) ? PG_W : CNT_W;
    localparam int RW     = PGX_W + 1;
    localparam int CMP_W  = (PIDX_W > PG_W) ? PIDX_W : PG_W;
    localparam int FW     = ((PIDX_W > CNT_W) ? PIDX_W : CNT_W) + 1;
    localparam int PB_W   = $clog2(PAGE_BYTES + 1);
    localparam int VP_W   = VPU_W + 1 + PB_W;
    localparam int EW     = ((VP_W > 32) ? VP_W : 32) + 1;

    // configuration
    logic [31:0]      phys_base_reg, heap_start_reg, heap_limit_reg;
    logic [CNT_W-1:0] pool_pages_reg;

    // request and heap state
    logic             req_kernel_reg;
    logic [CNT_W-1:0] req_count_reg;
    logic [VPU_W-1:0] vpu_reg, vpu_next;
    logic [VP_W-1:0]  vprod_reg, vprod_next;
    logic [VP_W-1:0]  vend_prod_reg, vend_prod_next;

    // search / mark
    logic [AW-1:0]     word_reg, word_next;
    logic [RW-1:0]     carry_reg, carry_next;
    logic [PIDX_W-1:0] first_reg, first_next;
    logic [PIDX_W-1:0] last_reg, last_next;
    logic [31:0]       phys_off_reg, phys_off_next;
    cpa_pkg::status_t  status_reg, status_next;

    // result register
    logic             m_tvalid_reg, m_tvalid_next;
    cpa_pkg::status_t m_status_reg, m_status_next;
    logic [31:0]      m_phys_reg, m_phys_next;
    logic [31:0]      m_virt_reg, m_virt_next;

    // bitmap
    logic          ram_we;
    logic [W-1:0]  ram_wdata, rd_data;

    cpa_ram #(
        .WIDTH (W),
        .DEPTH (NW)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .raddr (word_reg),
        .rdata (rd_data)
    );

    // effective pool size
    logic [PG_W-1:0] lim;
    logic [AW-1:0]   last_sw;
    logic [EW-1:0]   vend;

    assign lim = (PGX_W'(pool_pages_reg) > PGX_W'(MAX_PAGES)) ? PG_W'(MAX_PAGES)
                                                              : PG_W'(pool_pages_reg);
    assign last_sw = AW'((lim - PG_W'(1)) >> WB);
    assign vend    = EW'(heap_start_reg) + EW'(vend_prod_reg);

    // word evaluation: run length ending at each bit, first bit reaching the count
    logic [W-1:0]      used, hit_vec, mark_mask;
    logic [RW-1:0]     run [W];
    logic [WB-1:0]     hit_idx;
    logic [PIDX_W-1:0] page;
    logic              lu_found;
    logic [WB-1:0]     lu_pos;

    always_comb begin
        used     = rd_data;
        hit_vec  = '0;
        hit_idx  = '0;
        lu_found = 1'b0;
        lu_pos   = '0;
        page     = '0;
        for (int i = 0; i < W; i++) begin
            page = {word_reg, WB'(i)};
            if (CMP_W'(page) >= CMP_W'(lim)) begin
                used[i] = 1'b1;
            end
        end
        for (int i = 0; i < W; i++) begin
            lu_found = 1'b0;
            lu_pos   = '0;
            for (int j = 0; j < W; j++) begin
                if (j <= i && used[j]) begin
                    lu_found = 1'b1;
                    lu_pos   = WB'(j);
                end
            end
            if (lu_found) begin
                run[i] = RW'(WB'(i) - lu_pos);
            end else begin
                run[i] = carry_reg + RW'(i) + RW'(1);
            end
            hit_vec[i] = (run[i] >= RW'(req_count_reg));
        end
        for (int i = W - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = WB'(i);
            end
        end
    end

    always_comb begin
        mark_mask = '0;
        for (int i = 0; i < W; i++) begin
            mark_mask[i] = ({word_reg, WB'(i)} >= first_reg) &&
                           ({word_reg, WB'(i)} <= last_reg);
        end
    end

    assign ram_we    = cmd.clear_wr | cmd.mark_wr;
    assign ram_wdata = cmd.clear_wr ? '0 : (rd_data | mark_mask);

    // status back to the controller
    always_comb begin
        sts.clr_last   = (word_reg == AW'(NW - 1));
        sts.req_kernel = req_kernel_reg;
        sts.req_zero   = (req_count_reg == '0);
        sts.no_virt    = (vend > EW'(heap_limit_reg));
        sts.lim_zero   = (lim == '0);
        sts.hit        = |hit_vec;
        sts.srch_last  = (word_reg == last_sw);
        sts.mark_last  = (word_reg == last_reg[PIDX_W-1:WB]);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        vpu_next       = vpu_reg;
        word_next      = word_reg;
        carry_next     = carry_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_status_next  = m_status_reg;
        m_phys_next    = m_phys_reg;
        m_virt_next    = m_virt_reg;

        vprod_next     = VP_W'(vpu_reg) * VP_W'(PAGE_BYTES);
        vend_prod_next = VP_W'(({1'b0, vpu_reg} + (VPU_W + 1)'(req_count_reg)))
                         * VP_W'(PAGE_BYTES);
        phys_off_next  = 32'(first_reg) * 32'(PAGE_BYTES);

        // the hit word is still in the read register when marking starts
        priority if (cmd.srch_init) begin
            word_next  = '0;
            carry_next = '0;
        end else if (cmd.mark_init) begin
            first_next = PIDX_W'(FW'({word_reg, hit_idx}) + FW'(1) - FW'(req_count_reg));
            last_next  = {word_reg, hit_idx};
            word_next  = first_next[PIDX_W-1:WB];
        end else if (cmd.clear_wr || cmd.srch_next || cmd.mark_wr) begin
            word_next  = word_reg + AW'(1);
            carry_next = run[W-1];
        end else begin
            word_next = word_reg;
        end

        if (cmd.set_status) begin
            status_next = cmd.code;
        end

        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_status_next = status_reg;
            if (status_reg == cpa_pkg::STAT_OK) begin
                m_phys_next = phys_base_reg + phys_off_reg;
                m_virt_next = heap_start_reg + 32'(vprod_reg);
                vpu_next    = vpu_reg + VPU_W'(req_count_reg);
            end else begin
                m_phys_next = '0;
                m_virt_next = '0;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phys_base_reg  <= cpa_pkg::PHYS_BASE_RST;
            pool_pages_reg <= cpa_pkg::POOL_PAGES_RST;
            heap_start_reg <= cpa_pkg::HEAP_START_RST;
            heap_limit_reg <= cpa_pkg::HEAP_LIMIT_RST;
            vpu_reg        <= '0;
            word_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cpa_pkg::cfg_idx_t'(cfg_index))
                    cpa_pkg::CFG_PHYS_BASE:  phys_base_reg  <= cfg_data;
                    cpa_pkg::CFG_POOL_PAGES: pool_pages_reg <= cfg_data[CNT_W-1:0];
                    cpa_pkg::CFG_HEAP_START: heap_start_reg <= cfg_data;
                    cpa_pkg::CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            vpu_reg      <= vpu_next;
            word_reg     <= word_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_kernel_reg <= s_tuser[0];
            req_count_reg  <= s_tdata[CNT_W-1:0];
        end
        vprod_reg     <= vprod_next;
        vend_prod_reg <= vend_prod_next;
        carry_reg     <= carry_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        phys_off_reg  <= phys_off_next;
        status_reg    <= status_next;
        m_status_reg  <= m_status_next;
        m_phys_reg    <= m_phys_next;
        m_virt_reg    <= m_virt_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_virt_reg, m_phys_reg};

endmodule

`default_nettype wire

// ----- design/contiguous_page_allocator.sv -----
// Sequence: heap check, word-serial bitmap search (ceil(pool/32) words at most),
//   a mark sweep over each word the run spans, then the result is loaded.
// Requests: one at a time; a request rejected at the check goes straight to the
//   result, and the result waits while the output register is still full.
// Reset: synchronous, active low; then a sweep clears every bitmap word with
//   s_tready low. Config writes are taken throughout.
`default_nettype none
`include "contiguous_page_allocator_assert.svh"

module contiguous_page_allocator #(
    parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [10:0] page_count, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] pool_is_kernel
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] phys_start, [63:32] virt_start
    output logic [2:0]       m_tuser,   // [2:0] status
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cpa_pkg::cpa_cmd_t cmd;
    cpa_pkg::cpa_sts_t sts;

    // registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    // Controller: clear sweep, check, word-serial search, mark sweep, result.
    cpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: bitmap RAM, run tracking, heap arithmetic, result register.
    cpa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // An accepted request takes the block out of idle at once.
    `CPA_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A result is only loaded when the output register can take it.
    `CPA_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free)
    // Loading a result returns the block to idle and presents it.
    `CPA_ASSERT_NEXT(a_emit_idle, aclk, aresetn, cmd.emit, s_tready && m_tvalid)

endmodule

`default_nettype wire
